// ===== rtl/qrs_pkg.sv =====
// Shared types, widths and codes for the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

  // Coefficient format: signed Q(COEF_WIDTH-FRAC_BITS).FRAC_BITS
  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_W      = COEF_WIDTH - 1;
  localparam int STATUS_W   = 3;

  // Internal datapath widths
  localparam int PROD_W  = 2 * COEF_WIDTH;          // b*b and a*c
  localparam int DV_W    = PROD_W + 3;              // discriminant, signed
  localparam int BASE_W  = COEF_WIDTH + 1;          // -b or -c, signed
  localparam int DEN_W   = COEF_WIDTH + 2;          // b or 2a, signed
  localparam int SQ_W    = COEF_WIDTH + 1;          // square root result
  localparam int SQ_IN_W = 2 * SQ_W;                // square root radicand
  localparam int SR_W    = SQ_W + 2;                // square root remainder
  localparam int NUM_W   = COEF_WIDTH + 3;          // base +/- root, signed
  localparam int NMAG_W  = COEF_WIDTH + 2;          // numerator magnitude
  localparam int DMAG_W  = COEF_WIDTH + 1;          // denominator magnitude
  localparam int DD_W    = DMAG_W + 1;              // divisor 2*|den|
  localparam int QN_W    = NMAG_W + FRAC_BITS + 2;  // dividend and quotient

  // Queue depths
  localparam int QUEUE_DEPTH_DEF  = 4;
  localparam int RESULT_DEPTH_DEF = 4;

  // Status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_NONE    = 3'd0;
  localparam status_t ST_ONE     = 3'd1;
  localparam status_t ST_TWO     = 3'd2;
  localparam status_t ST_INF     = 3'd3;
  localparam status_t ST_INVALID = 3'd4;

  // What the back end has to compute for a request
  typedef enum logic [1:0] {
    KIND_FIXED,   // no division, roots are zero
    KIND_SINGLE,  // one division, both roots equal
    KIND_PAIR     // square root, then two divisions
  } kind_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_const;
    logic signed [COEF_WIDTH-1:0] coef_linear;
    logic signed [COEF_WIDTH-1:0] coef_square;
    logic [1:0]                   coef_count;
    logic                         higher_nonzero;
  } req_t;

  typedef struct packed {
    status_t                      status;
    logic signed [COEF_WIDTH-1:0] root_first;
    logic signed [COEF_WIDTH-1:0] root_second;
    logic                         overflow;
  } res_t;

  // Control and operands that follow a request through the back end
  typedef struct packed {
    status_t                  status;
    kind_t                    kind;
    logic signed [BASE_W-1:0] base;
    logic signed [DEN_W-1:0]  den;
  } tag_t;

  typedef struct packed {
    tag_t                 tag;
    logic [SQ_IN_W-1:0]   radicand;
  } job_t;

endpackage

// ===== rtl/qrs_fifo.sv =====
// Small first-in first-out queue with registered storage.
`timescale 1ns / 1ps
module qrs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/qrs_front.sv =====
// Front end: accepts requests, classifies them and forms the back-end jobs.
`timescale 1ns / 1ps
module qrs_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  qrs_pkg::req_t              req,
  input  logic [qrs_pkg::TOL_W-1:0]  tolerance,
  output logic                       job_push,
  output qrs_pkg::job_t              job,
  input  logic                       job_full
);
  import qrs_pkg::*;

  function automatic logic [COEF_WIDTH-1:0] coef_mag(input logic signed [COEF_WIDTH-1:0] v);
    return v[COEF_WIDTH-1] ? COEF_WIDTH'(-v) : COEF_WIDTH'(v);
  endfunction

  logic front_en;

  // stage 1 registers
  logic                         s1_valid;
  logic                         s1_invalid, s1_a_small, s1_b_small, s1_c_small;
  logic signed [COEF_WIDTH-1:0] s1_a, s1_b, s1_c;
  logic [PROD_W-1:0]            s1_bb;
  logic signed [PROD_W-1:0]     s1_ac;

  // stage 2 registers
  logic s2_valid;
  job_t s2_job;

  // coefficient selection by count
  logic signed [COEF_WIDTH-1:0] ca, cb, cc;
  logic signed [PROD_W-1:0]     bb_full;

  // stage 2 classification
  logic signed [DV_W-1:0] dv, tol_pos, tol_neg;
  logic                   above, in_band;
  job_t                   job_next;

  // whole front advances unless the last stage is blocked
  assign front_en = !(s2_valid && job_full);
  assign full     = !front_en;
  assign job_push = s2_valid && !job_full;
  assign job      = s2_job;

  // missing coefficients read as zero
  always_comb begin
    cc      = req.coef_const;
    cb      = (req.coef_count == 2'd1) ? '0 : req.coef_linear;
    ca      = (req.coef_count == 2'd3) ? req.coef_square : '0;
    bb_full = cb * cb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (front_en) begin
      s1_valid <= push;
    end
  end

  // tolerance tests and the two products
  always_ff @(posedge clk) begin
    if (front_en) begin
      s1_invalid <= req.higher_nonzero || (req.coef_count == 2'd0);
      s1_a_small <= coef_mag(ca) <= COEF_WIDTH'(tolerance);
      s1_b_small <= coef_mag(cb) <= COEF_WIDTH'(tolerance);
      s1_c_small <= coef_mag(cc) <= COEF_WIDTH'(tolerance);
      s1_a       <= ca;
      s1_b       <= cb;
      s1_c       <= cc;
      s1_bb      <= PROD_W'(bb_full);
      s1_ac      <= ca * cc;
    end
  end

  // discriminant b*b - 4ac against +/- tolerance, then pick the job
  always_comb begin
    dv      = DV_W'($signed({1'b0, s1_bb})) - (DV_W'(s1_ac) <<< 2);
    tol_pos = $signed({{(DV_W - TOL_W - FRAC_BITS){1'b0}}, tolerance, {FRAC_BITS{1'b0}}});
    tol_neg = -tol_pos;
    above   = dv > tol_pos;
    in_band = dv >= tol_neg;

    job_next = '0;
    job_next.tag.kind = KIND_FIXED;
    if (s1_invalid) begin
      job_next.tag.status = ST_INVALID;
    end else if (s1_a_small) begin
      if (s1_b_small) begin
        job_next.tag.status = s1_c_small ? ST_INF : ST_NONE;
      end else begin
        // linear: -c / b
        job_next.tag.status = ST_ONE;
        job_next.tag.kind   = KIND_SINGLE;
        job_next.tag.base   = -(BASE_W'(s1_c));
        job_next.tag.den    = DEN_W'(s1_b);
      end
    end else if (above) begin
      job_next.tag.status = ST_TWO;
      job_next.tag.kind   = KIND_PAIR;
      job_next.tag.base   = -(BASE_W'(s1_b));
      job_next.tag.den    = DEN_W'(s1_a) <<< 1;
      job_next.radicand   = dv[SQ_IN_W-1:0];
    end else if (in_band) begin
      // double root: -b / 2a
      job_next.tag.status = ST_ONE;
      job_next.tag.kind   = KIND_SINGLE;
      job_next.tag.base   = -(BASE_W'(s1_b));
      job_next.tag.den    = DEN_W'(s1_a) <<< 1;
    end else begin
      job_next.tag.status = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (front_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      s2_job <= job_next;
    end
  end

endmodule

// ===== rtl/qrs_back.sv =====
// Back end: pipelined square root, two pipelined rounding dividers, saturation.
`timescale 1ns / 1ps
module qrs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_empty,
  output logic          job_pop,
  input  qrs_pkg::job_t job,
  input  logic          res_full,
  output logic          res_push,
  output qrs_pkg::res_t res
);
  import qrs_pkg::*;

  localparam logic [QN_W-1:0] Q_NEG_LIM = QN_W'(1) << (COEF_WIDTH - 1);
  localparam logic [QN_W-1:0] Q_POS_LIM = Q_NEG_LIM - 1'b1;

  // saturate a quotient magnitude; result is {overflow, root}
  function automatic logic [COEF_WIDTH:0] sat_root(input logic [QN_W-1:0] q,
                                                   input logic neg);
    logic [COEF_WIDTH-1:0] r;
    logic                  o;
    if (neg) begin
      o = q > Q_NEG_LIM;
      r = o ? COEF_WIDTH'(Q_NEG_LIM) : COEF_WIDTH'(-q);
    end else begin
      o = q > Q_POS_LIM;
      r = o ? COEF_WIDTH'(Q_POS_LIM) : COEF_WIDTH'(q);
    end
    return {o, r};
  endfunction

  logic back_en;

  // square root stages: one result bit each
  logic               sq_valid [0:SQ_W];
  tag_t               sq_tag   [0:SQ_W];
  logic [SQ_IN_W-1:0] sq_rad   [0:SQ_W];
  logic [SR_W-1:0]    sq_rem   [0:SQ_W];
  logic [SQ_W-1:0]    sq_res   [0:SQ_W];

  // divider stages: one quotient bit each, two lanes
  logic             dv_valid [0:QN_W];
  tag_t             dv_tag   [0:QN_W];
  logic [DD_W-1:0]  dv_d     [0:QN_W];
  logic [QN_W-1:0]  dv_nq    [0:1][0:QN_W];
  logic [DD_W-1:0]  dv_rem   [0:1][0:QN_W];
  logic             dv_neg   [0:1][0:QN_W];

  // numerator set-up
  logic signed [NUM_W-1:0] num [0:1];
  logic [NMAG_W-1:0]       nmag [0:1];
  logic [DMAG_W-1:0]       dmag;
  tag_t                    nt;
  logic                    den_neg;

  // output
  logic [COEF_WIDTH:0] sr1, sr2;
  tag_t                ft;

  // the whole back end moves unless its result cannot be queued
  assign back_en  = !(dv_valid[QN_W] && res_full);
  assign job_pop  = back_en && !job_empty;
  assign res_push = dv_valid[QN_W] && !res_full;

  // entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (back_en) begin
      sq_valid[0] <= !job_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      sq_tag[0] <= job.tag;
      sq_rad[0] <= job.radicand;
      sq_rem[0] <= '0;
      sq_res[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    logic [SR_W-1:0] rem_sh, trial;
    logic            take;

    always_comb begin
      rem_sh = {sq_rem[k][SR_W-3:0], sq_rad[k][SQ_IN_W-1 -: 2]};
      trial  = {sq_res[k], 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k+1] <= 1'b0;
      end else if (back_en) begin
        sq_valid[k+1] <= sq_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (back_en) begin
        sq_tag[k+1] <= sq_tag[k];
        sq_rad[k+1] <= sq_rad[k] << 2;
        sq_rem[k+1] <= take ? rem_sh - trial : rem_sh;
        sq_res[k+1] <= {sq_res[k][SQ_W-2:0], take};
      end
    end
  end

  // numerators base +/- s (s is zero unless a pair), magnitudes and signs
  always_comb begin
    nt      = sq_tag[SQ_W];
    num[0]  = NUM_W'(nt.base) + $signed(NUM_W'(sq_res[SQ_W]));
    num[1]  = NUM_W'(nt.base) - $signed(NUM_W'(sq_res[SQ_W]));
    nmag[0] = NMAG_W'(num[0][NUM_W-1] ? -num[0] : num[0]);
    nmag[1] = NMAG_W'(num[1][NUM_W-1] ? -num[1] : num[1]);
    den_neg = nt.den[DEN_W-1];
    dmag    = DMAG_W'(den_neg ? -nt.den : nt.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (back_en) begin
      dv_valid[0] <= sq_valid[SQ_W];
    end
  end

  // dividend 2*|num|*2^F + |den|, divisor 2*|den|: rounds half away from zero
  always_ff @(posedge clk) begin
    if (back_en) begin
      dv_tag[0] <= nt;
      dv_d[0]   <= {dmag, 1'b0};
      for (int l = 0; l < 2; l++) begin
        dv_nq[l][0]  <= QN_W'({nmag[l], {(FRAC_BITS + 1){1'b0}}}) + QN_W'(dmag);
        dv_rem[l][0] <= '0;
        dv_neg[l][0] <= num[l][NUM_W-1] ^ den_neg;
      end
    end
  end

  for (genvar k = 0; k < QN_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (back_en) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (back_en) begin
        dv_tag[k+1] <= dv_tag[k];
        dv_d[k+1]   <= dv_d[k];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DD_W:0] rem_sh;
      logic          take;

      always_comb begin
        rem_sh = {dv_rem[l][k], dv_nq[l][k][QN_W-1]};
        take   = rem_sh >= {1'b0, dv_d[k]};
      end

      always_ff @(posedge clk) begin
        if (back_en) begin
          dv_rem[l][k+1] <= DD_W'(take ? rem_sh - {1'b0, dv_d[k]} : rem_sh);
          dv_nq[l][k+1]  <= {dv_nq[l][k][QN_W-2:0], take};
          dv_neg[l][k+1] <= dv_neg[l][k];
        end
      end
    end
  end

  // saturate and assemble the result
  always_comb begin
    ft  = dv_tag[QN_W];
    sr1 = sat_root(dv_nq[0][QN_W], dv_neg[0][QN_W]);
    sr2 = sat_root(dv_nq[1][QN_W], dv_neg[1][QN_W]);
    res = '0;
    res.status = ft.status;
    unique case (ft.kind)
      KIND_SINGLE: begin
        res.root_first  = sr1[COEF_WIDTH-1:0];
        res.root_second = sr1[COEF_WIDTH-1:0];
        res.overflow    = sr1[COEF_WIDTH];
      end
      KIND_PAIR: begin
        res.root_first  = sr1[COEF_WIDTH-1:0];
        res.root_second = sr2[COEF_WIDTH-1:0];
        res.overflow    = sr1[COEF_WIDTH] | sr2[COEF_WIDTH];
      end
      default: begin
        res.root_first  = '0;
        res.root_second = '0;
        res.overflow    = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: queues, front and back ends, register port.
`timescale 1ns / 1ps
// Solves a*x^2 + b*x + c = 0 for real roots in signed Q16.16. One request enters per
// cycle while full is low, and one result leaves per cycle when pop is held; results
// come out in request order. Each request passes the square root stage, which makes
// one root bit per stage, and then the two rounding dividers, which make one quotient
// bit per stage. A full result queue stalls the back end, and a full job queue then
// stalls the front end and raises full.
// The tolerance register sits at address 0 and resets to 1; write it only while idle.
module quadratic_root_solver #(
  parameter int QUEUE_DEPTH  = qrs_pkg::QUEUE_DEPTH_DEF,
  parameter int RESULT_DEPTH = qrs_pkg::RESULT_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  // request side
  input  logic          push,
  output logic          full,
  input  qrs_pkg::req_t req,
  // result side
  output logic          empty,
  input  logic          pop,
  output qrs_pkg::res_t res,
  // register port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import qrs_pkg::*;

  localparam logic REG_TOLERANCE = 1'b0;

  logic [TOL_W-1:0]      tolerance;
  logic                  cfg_wr;

  logic                  job_push, job_full, job_pop, job_empty;
  job_t                  job_in, job_out;
  logic [$bits(job_t)-1:0] job_bits;

  logic                  res_push, res_full;
  res_t                  res_in;
  logic [$bits(res_t)-1:0] res_bits;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TOLERANCE) ? {1'b0, tolerance} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_W'(1);
    end else if (cfg_wr && (paddr[2] == REG_TOLERANCE)) begin
      tolerance <= pwdata[TOL_W-1:0];
    end
  end

  qrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .tolerance (tolerance),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full)
  );

  qrs_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_bits),
    .empty   (job_empty)
  );

  assign job_out = job_t'(job_bits);

  qrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job_out),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  qrs_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_bits),
    .empty   (empty)
  );

  assign res = res_t'(res_bits);

  // checks
  a_job_no_overrun: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full) else $error("job pushed into a full queue");

  a_res_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full) else $error("result pushed into a full queue");

  a_no_root_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (res.status == ST_NONE || res.status == ST_INF || res.status == ST_INVALID))
    |-> (res.root_first == '0 && res.root_second == '0 && !res.overflow))
    else $error("nonzero root on a rootless result");

  a_one_root_equal: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.status == ST_ONE) |-> (res.root_first == res.root_second))
    else $error("single root result with differing roots");

endmodule
